@@ design/stlt_pkg.sv @@
// Shared types, constants and helper functions for the sound-triggered hold light timer.
// No dependencies; every other design file imports this package.
package stlt_pkg;

  // Field widths
  localparam int ACT_W      = 3;
  localparam int MIC_W      = 12;
  localparam int THR_W      = 12;
  localparam int SECS_W     = 7;
  localparam int TICKS_W    = 10;
  localparam int SEG_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Parameter defaults
  localparam int TICKS_PER_SECOND_DEF = 10;
  localparam int SAMPLE_BITS_DEF      = 12;

  // Limits and reset values
  localparam int                TICKS_MAX    = 1023;
  localparam logic [THR_W-1:0]  THR_MAX      = 12'd4095;
  localparam logic [THR_W-1:0]  THR_RESET    = 12'd2000;
  localparam logic [THR_W-1:0]  STEP_RESET   = 12'd50;
  localparam logic [SECS_W-1:0] SECS_MAX     = 7'd99;
  localparam logic [SECS_W-1:0] HOLD_RESET   = 7'd10;

  // Event codes
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MODE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UP     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DOWN   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'd1;

  // Reciprocal constants, exact for every 12-bit dividend
  localparam int DIV10_MUL     = 6554;
  localparam int DIV10_SHIFT   = 16;
  localparam int DIV100_MUL    = 2622;
  localparam int DIV100_SHIFT  = 18;
  localparam int DIV1000_MUL   = 4195;
  localparam int DIV1000_SHIFT = 22;
  localparam int PROD_W        = 29;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [MIC_W-1:0] mic_sample;
  } in_word_t;

  typedef struct packed {
    logic              light_on;
    logic              setting_mode;
    logic [THR_W-1:0]  threshold_now;
    logic [SECS_W-1:0] seconds_left;
    logic [SEG_W-1:0]  segments_digit0;
    logic [SEG_W-1:0]  segments_digit1;
    logic [SEG_W-1:0]  segments_digit2;
    logic [SEG_W-1:0]  segments_digit3;
  } out_word_t;

  // Snapshot of the timer state after one event, handed to the display stage
  typedef struct packed {
    logic              light;
    logic              mode;
    logic [THR_W-1:0]  thr;
    logic [SECS_W-1:0] secs;
    logic [SECS_W-1:0] hold;
  } status_t;

  // Quotients by constants through reciprocal multiplication
  function automatic logic [THR_W-1:0] div10(input logic [THR_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(DIV10_MUL);
    return THR_W'(p >> DIV10_SHIFT);
  endfunction

  function automatic logic [THR_W-1:0] div100(input logic [THR_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(DIV100_MUL);
    return THR_W'(p >> DIV100_SHIFT);
  endfunction

  function automatic logic [THR_W-1:0] div1000(input logic [THR_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(DIV1000_MUL);
    return THR_W'(p >> DIV1000_SHIFT);
  endfunction

  // Low decimal digit of x given q = x / 10
  function automatic logic [3:0] low_digit(input logic [THR_W-1:0] x,
                                           input logic [THR_W-1:0] q);
    logic [THR_W-1:0] r;
    r = x - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction

  // Common-cathode seven-segment code of one decimal digit
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ design/stlt_ctrl.sv @@
// Timer state update stage: configuration registers, mode, threshold, light and countdown.
// Depends on stlt_pkg. Emits a registered status snapshot per event.
module stlt_ctrl #(
  parameter int TICKS_PER_SECOND = stlt_pkg::TICKS_PER_SECOND_DEF,
  parameter int SAMPLE_W         = stlt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             item_valid_i,
  input  logic [stlt_pkg::ACT_W-1:0]       action_i,
  input  logic [SAMPLE_W-1:0]              sample_i,
  input  logic                             cfg_we_i,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             status_valid_o,
  output stlt_pkg::status_t                status_o
);
  import stlt_pkg::*;

  // Countdown kept as whole seconds plus ticks within the current second:
  // ticks = (secs - 1) * TICKS_PER_SECOND + rem while secs is nonzero.
  localparam int REM_W     = $clog2(TICKS_PER_SECOND + 1);
  localparam int CapSecs   = TICKS_MAX / TICKS_PER_SECOND;
  localparam int CeilSecs  = (TICKS_MAX + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int CapRem    = TICKS_MAX - (CeilSecs - 1) * TICKS_PER_SECOND;
  localparam logic [TICKS_W-1:0] CAP_SECS_V  = TICKS_W'(CapSecs);
  localparam logic [SECS_W-1:0]  CEIL_SECS_V = SECS_W'(CeilSecs);
  localparam logic [REM_W-1:0]   CAP_REM_V   = REM_W'(CapRem);
  localparam logic [REM_W-1:0]   FULL_REM_V  = REM_W'(TICKS_PER_SECOND);
  localparam logic [REM_W-1:0]   ONE_REM_V   = REM_W'(1);

  logic [THR_W-1:0]  step_q;
  logic [SECS_W-1:0] hold_q;
  logic              mode_q, mode_d;
  logic              light_q, light_d;
  logic [THR_W-1:0]  thr_q, thr_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [SECS_W-1:0] eff_hold;
  logic [THR_W:0]    up_sum;
  logic              step_en;
  logic              status_valid_q;
  status_t           status_q;

  assign step_en = adv_i && item_valid_i;

  // Clamp the hold time to one through 99 seconds
  always_comb begin
    eff_hold = hold_q;
    if (hold_q == '0) begin
      eff_hold = SECS_W'(1);
    end else if (hold_q > SECS_MAX) begin
      eff_hold = SECS_MAX;
    end
  end

  assign up_sum = {1'b0, thr_q} + {1'b0, step_q};

  // Apply one event to the timer state
  always_comb begin
    mode_d  = mode_q;
    light_d = light_q;
    thr_d   = thr_q;
    secs_d  = secs_q;
    rem_d   = rem_q;
    unique case (action_i)
      ACT_SAMPLE: begin
        if (!mode_q && (THR_W'(sample_i) > thr_q)) begin
          light_d = 1'b1;
          if ({{(TICKS_W-SECS_W){1'b0}}, eff_hold} > CAP_SECS_V) begin
            secs_d = CEIL_SECS_V;
            rem_d  = CAP_REM_V;
          end else begin
            secs_d = eff_hold;
            rem_d  = FULL_REM_V;
          end
        end
      end
      ACT_TICK: begin
        if (mode_q) begin
          light_d = 1'b0;
          secs_d  = '0;
        end else if (light_q && (secs_q != '0)) begin
          if (rem_q == ONE_REM_V) begin
            secs_d = secs_q - SECS_W'(1);
            rem_d  = FULL_REM_V;
            if (secs_q == SECS_W'(1)) begin
              light_d = 1'b0;
            end
          end else begin
            rem_d = rem_q - ONE_REM_V;
          end
        end
      end
      ACT_MODE: begin
        mode_d  = !mode_q;
        light_d = 1'b0;
        secs_d  = '0;
      end
      ACT_UP: begin
        if (mode_q) begin
          thr_d = up_sum[THR_W] ? THR_MAX : up_sum[THR_W-1:0];
        end
      end
      ACT_DOWN: begin
        if (mode_q) begin
          thr_d = (thr_q >= step_q) ? (thr_q - step_q) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP: step_q <= cfg_data_i;
        CFG_HOLD: hold_q <= cfg_data_i[SECS_W-1:0];
      endcase
    end
  end

  // Timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      light_q <= 1'b0;
      thr_q   <= THR_RESET;
      secs_q  <= '0;
      rem_q   <= FULL_REM_V;
    end else if (step_en) begin
      mode_q  <= mode_d;
      light_q <= light_d;
      thr_q   <= thr_d;
      secs_q  <= secs_d;
      rem_q   <= rem_d;
    end
  end

  // Status snapshot stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_valid_q <= 1'b0;
    end else if (adv_i) begin
      status_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      status_q <= '{light: light_d, mode: mode_d, thr: thr_d, secs: secs_d, hold: eff_hold};
    end
  end

  assign status_valid_o = status_valid_q;
  assign status_o       = status_q;

endmodule

@@ design/stlt_disp.sv @@
// Display stage: seconds readout and seven-segment digit codes, then the result register.
// Depends on stlt_pkg.
module stlt_disp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                status_valid_i,
  input  stlt_pkg::status_t   status_i,
  output logic                out_valid_o,
  output stlt_pkg::out_word_t out_word_o
);
  import stlt_pkg::*;

  logic [SECS_W-1:0] secs_show;
  logic [THR_W-1:0]  secs_ext;
  logic [THR_W-1:0]  secs_q10;
  logic [THR_W-1:0]  thr_q10;
  logic [THR_W-1:0]  thr_q100;
  logic [THR_W-1:0]  thr_q1000;
  logic              run_active;
  out_word_t         word_d;
  out_word_t         word_q;
  logic              valid_q;

  // Cap the readout at the current hold time
  assign secs_show = (status_i.secs > status_i.hold) ? status_i.hold : status_i.secs;
  assign secs_ext  = THR_W'(secs_show);
  assign secs_q10  = div10(secs_ext);

  // Decimal digits of the threshold
  assign thr_q10   = div10(status_i.thr);
  assign thr_q100  = div100(status_i.thr);
  assign thr_q1000 = div1000(status_i.thr);

  assign run_active = status_i.light || (status_i.secs != '0);

  // Build the result word
  always_comb begin
    word_d.light_on      = status_i.light;
    word_d.setting_mode  = status_i.mode;
    word_d.threshold_now = status_i.thr;
    word_d.seconds_left  = secs_show;
    if (status_i.mode) begin
      word_d.segments_digit0 = seg_of(thr_q1000[3:0]);
      word_d.segments_digit1 = seg_of(low_digit(thr_q100, thr_q1000));
      word_d.segments_digit2 = seg_of(low_digit(thr_q10, thr_q100));
      word_d.segments_digit3 = seg_of(low_digit(status_i.thr, thr_q10));
    end else if (run_active) begin
      word_d.segments_digit0 = seg_of(secs_q10[3:0]);
      word_d.segments_digit1 = seg_of(low_digit(secs_ext, secs_q10));
      word_d.segments_digit2 = '0;
      word_d.segments_digit3 = '0;
    end else begin
      word_d.segments_digit0 = '0;
      word_d.segments_digit1 = '0;
      word_d.segments_digit2 = '0;
      word_d.segments_digit3 = '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= status_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && status_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

@@ design/sound_triggered_hold_light_timer.sv @@
// Top level of the sound-triggered hold light timer: input register, state stage, display stage.
// Depends on stlt_pkg, stlt_ctrl and stlt_disp.
//
// The block takes one event word per clock while in_stall_o is low (a mic sample, a tick, a
// mode key, an up key or a down key) and returns exactly one result word per event. It offers
// each result word after its event has passed the input and state stages; it is taken at the
// next unstalled edge. The path is a three-register pipeline: the input register, the
// state stage that updates mode, threshold, light and countdown and snapshots them, and the
// display stage that builds the seconds readout and seven-segment codes into the result
// register. Each stage holds its word while the next is full, so a new event is accepted in
// every cycle that the pipeline has a free slot, also while a finished result waits. The
// configuration port is always ready; write it only while no event is in flight.
module sound_triggered_hold_light_timer #(
  parameter int TICKS_PER_SECOND = stlt_pkg::TICKS_PER_SECOND_DEF,
  parameter int SAMPLE_BITS      = stlt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  stlt_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stlt_pkg::out_word_t              out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import stlt_pkg::*;

  localparam int SAMPLE_W = (SAMPLE_BITS < MIC_W) ? SAMPLE_BITS : MIC_W;

  logic                in_v_q;
  logic [ACT_W-1:0]    act_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                status_valid;
  status_t             status;
  logic                adv_out;
  logic                adv_ctrl;
  logic                adv_in;

  // Advance each stage when the one after it can take its word
  assign adv_out  = !out_valid_o || !out_stall_i;
  assign adv_ctrl = !status_valid || adv_out;
  assign adv_in   = !in_v_q || adv_ctrl;

  assign in_stall_o  = !adv_in;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv_in) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      act_q    <= in_word_i.action;
      sample_q <= in_word_i.mic_sample[SAMPLE_W-1:0];
    end
  end

  stlt_ctrl #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SAMPLE_W         (SAMPLE_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv_ctrl),
    .item_valid_i   (in_v_q),
    .action_i       (act_q),
    .sample_i       (sample_q),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .status_valid_o (status_valid),
    .status_o       (status)
  );

  stlt_disp u_disp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv_out),
    .status_valid_i (status_valid),
    .status_i       (status),
    .out_valid_o    (out_valid_o),
    .out_word_o     (out_word_o)
  );

endmodule

@@ design/stlt_checker.sv @@
// Port-level checks on the result channel of the light timer, bound to the top level.
// Depends on stlt_pkg and sound_triggered_hold_light_timer.
module stlt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input stlt_pkg::out_word_t out_word_o
);
  import stlt_pkg::*;

  // A stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // The light is never latched in set mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.light_on |-> !out_word_o.setting_mode)
    else $error("light latched in set mode");

  // A latched light always has time left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.light_on |-> out_word_o.seconds_left != '0)
    else $error("light latched with no time left");

  // Readout stays within two digits; set mode always shows a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.seconds_left <= SECS_MAX) &&
                    (!out_word_o.setting_mode || out_word_o.segments_digit3 != '0))
    else $error("display word out of range");

endmodule

bind sound_triggered_hold_light_timer stlt_checker u_stlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
